// ----- rtl/owner_tagged_slot_allocator_macros.svh -----
// Assertion macros for the owner-tagged slot allocator.
`ifndef OWNER_TAGGED_SLOT_ALLOCATOR_MACROS_SVH
`define OWNER_TAGGED_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define OSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/osa_pkg.sv -----
// Shared types and codes for the owner-tagged slot allocator.
`timescale 1ns / 1ps

package osa_pkg;

   localparam int REQ_COUNT_WIDTH = 7;
   localparam int REQ_OWNER_WIDTH = 8;
   localparam int RSP_FREE_WIDTH  = 7;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_RELEASED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } osa_state_type;

   // Control part of the token that walks down the cell chain.
   typedef struct packed {
      logic valid;
      logic release_op;
   } token_ctl_type;

endpackage

// ----- rtl/osa_cell.sv -----
// One slot of the allocator chain: slot state plus the token register to the next cell.
`timescale 1ns / 1ps

module osa_cell
   import osa_pkg::*;
#(
   parameter int OWNER_WIDTH = 8,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  token_ctl_type          tok_ctl_prev,
   input  logic [OWNER_WIDTH-1:0] tok_owner_prev,
   input  logic [COUNT_WIDTH-1:0] tok_count_prev,
   output token_ctl_type          tok_ctl_next,
   output logic [OWNER_WIDTH-1:0] tok_owner_next,
   output logic [COUNT_WIDTH-1:0] tok_count_next
);

   logic                   taken_ff, taken_in;
   logic [OWNER_WIDTH-1:0] owner_ff, owner_in;
   token_ctl_type          ctl_ff, ctl_in;
   logic [OWNER_WIDTH-1:0] tok_owner_ff, tok_owner_in;
   logic [COUNT_WIDTH-1:0] tok_count_ff, tok_count_in;

   always_comb begin
      taken_in     = taken_ff;
      owner_in     = owner_ff;
      ctl_in       = tok_ctl_prev;
      tok_owner_in = tok_owner_prev;
      tok_count_in = tok_count_prev;
      if (tok_ctl_prev.valid) begin
         if (tok_ctl_prev.release_op) begin
            if (taken_ff && (owner_ff == tok_owner_prev)) begin
               taken_in     = 1'b0;
               tok_count_in = tok_count_prev + COUNT_WIDTH'(1);
            end
         end else begin
            if (!taken_ff && (tok_count_prev != '0)) begin
               taken_in     = 1'b1;
               owner_in     = tok_owner_prev;
               tok_count_in = tok_count_prev - COUNT_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= 1'b0;
         ctl_ff   <= '0;
      end else begin
         taken_ff <= taken_in;
         ctl_ff   <= ctl_in;
      end
      owner_ff     <= owner_in;
      tok_owner_ff <= tok_owner_in;
      tok_count_ff <= tok_count_in;
   end

   assign tok_ctl_next   = ctl_ff;
   assign tok_owner_next = tok_owner_ff;
   assign tok_count_next = tok_count_ff;

endmodule

// ----- rtl/owner_tagged_slot_allocator.sv -----
// Timing: a refused allocate answers in the cycle after acceptance; a grant or a
// release walks a token down the chain of SLOTS cells, one cell per cycle, and
// answers after the token leaves the last cell.
// Throughput: one request at a time; the next is taken only after the response is accepted.
// Reset (synchronous, active high) frees every slot at once; no clearing pass.
`timescale 1ns / 1ps
`include "owner_tagged_slot_allocator_macros.svh"

module owner_tagged_slot_allocator
   import osa_pkg::*;
#(
   parameter int SLOTS       = 64,
   parameter int OWNER_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // owner_id[7:0], request_count[14:8], zero pad
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // free_count[6:0], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CW   = $clog2(SLOTS + 1);
   localparam int CMPW = (CW > REQ_COUNT_WIDTH) ? CW : REQ_COUNT_WIDTH;

   osa_state_type        state_ff, state_in;
   status_type           status_ff, status_in;
   logic [CW-1:0]        free_count_ff, free_count_in;

   token_ctl_type        ctl_chain   [0:SLOTS];
   logic [OWNER_WIDTH-1:0] owner_chain [0:SLOTS];
   logic [CW-1:0]        count_chain [0:SLOTS];

   logic                       req_op;
   logic [OWNER_WIDTH-1:0]     req_owner;
   logic [REQ_COUNT_WIDTH-1:0] req_count;
   logic                       launch;

   logic                       req_beat;
   logic                       refuse_full;
   logic                       full_done;
   logic                       tail_valid;
   logic                       in_run;
   logic                       free_ok;

   assign req_op    = req_tuser[0];
   assign req_owner = OWNER_WIDTH'(req_tdata[REQ_OWNER_WIDTH-1:0]);
   assign req_count = req_tdata[REQ_OWNER_WIDTH +: REQ_COUNT_WIDTH];

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      free_count_in = free_count_ff;
      launch        = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == OP_RELEASE) begin
                  status_in = STATUS_RELEASED;
                  launch    = 1'b1;
                  state_in  = ST_RUN;
               end else if (free_count_ff == '0) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_DONE;
               end else if (CMPW'(req_count) > CMPW'(free_count_ff)) begin
                  status_in = STATUS_SHORT;
                  state_in  = ST_DONE;
               end else begin
                  status_in     = STATUS_GRANTED;
                  free_count_in = free_count_ff - CW'(req_count);
                  launch        = 1'b1;
                  state_in      = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (ctl_chain[SLOTS].valid) begin
               if (ctl_chain[SLOTS].release_op) begin
                  free_count_in = free_count_ff + count_chain[SLOTS];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= CW'(SLOTS);
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
      end
      status_ff <= status_in;
   end

   // Token entering the head of the chain.
   assign ctl_chain[0].valid      = launch;
   assign ctl_chain[0].release_op = req_op;
   assign owner_chain[0]          = req_owner;
   assign count_chain[0]          = (req_op == OP_RELEASE) ? '0 : CW'(req_count);

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      osa_cell #(
         .OWNER_WIDTH (OWNER_WIDTH),
         .COUNT_WIDTH (CW)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .tok_ctl_prev   (ctl_chain[i]),
         .tok_owner_prev (owner_chain[i]),
         .tok_count_prev (count_chain[i]),
         .tok_ctl_next   (ctl_chain[i+1]),
         .tok_owner_next (owner_chain[i+1]),
         .tok_count_next (count_chain[i+1])
      );
   end

   assign rsp_tdata = {1'b0, RSP_FREE_WIDTH'(free_count_ff)};
   assign rsp_tuser = status_ff;

   assign req_beat    = req_tvalid && req_tready;
   assign refuse_full = req_beat && (req_op == OP_ALLOCATE) && (free_count_ff == '0);
   assign full_done   = (status_ff == STATUS_FULL) && (state_ff == ST_DONE);
   assign tail_valid  = ctl_chain[SLOTS].valid;
   assign in_run      = (state_ff == ST_RUN);
   assign free_ok     = (free_count_ff <= CW'(SLOTS));

   `OSA_ASSERT_NOW(a_free_bound, clock, reset, 1'b1, free_ok, "free count above table size")
   `OSA_ASSERT_NOW(a_tail_in_run, clock, reset, tail_valid, in_run, "chain token outside run")
   `OSA_ASSERT_NEXT(a_full_status, clock, reset, refuse_full, full_done, "full not refused")
   `OSA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_beat, !req_tready, "beat taken while busy")

endmodule
